// ===== rtl/pidc_pkg.sv =====
// Package for the PID controller step block: configuration register indexes
// and the fixed-point bounds used by the datapath. No dependencies.
`default_nettype none

package pidc_pkg;

  // Configuration register indexes, in register-map order.
  typedef enum logic [1:0] {
    REG_KP_GAIN        = 2'd0,
    REG_KI_GAIN        = 2'd1,
    REG_KD_GAIN        = 2'd2,
    REG_INTEGRAL_LIMIT = 2'd3
  } cfg_reg_e;

  // The anti-windup bounds of ki*I, +/-1.0 in Q.16.
  localparam logic signed [47:0] ONE_Q16       = 48'sd65536;
  localparam logic signed [47:0] NEG_ONE_Q16   = -48'sd65536;

  // The output bounds of the raw sum, +/-3.0 in Q.16.
  localparam logic signed [49:0] THREE_Q16     = 50'sd196608;
  localparam logic signed [49:0] NEG_THREE_Q16 = -50'sd196608;

  // Half an output LSB in Q.16, for round to nearest.
  localparam logic signed [19:0] HALF_LSB_Q16  = 20'sd128;

endpackage

`default_nettype wire

// ===== rtl/pid_controller_step.sv =====
// Top level of the PID controller step block: a three-register pipeline that
// turns one error sample into one saturated drive value. Depends on pidc_pkg.
//
// Usage:
//   Error samples (signed Q8.8) enter on the in_* channel, one word per
//   handshake. Each accepted word yields exactly one result word on the out_*
//   channel: the drive value, signed Q3.8 saturated to +/-3.0, and a flag that
//   tells whether the raw sum went past that saturation bound.
//   Gains and the integral limit are written through the cfg_* channel, which
//   is always ready. They must be written only while no sample is in flight.
//   Path: a sample accepted on in_* reaches the out_* ports through the input
//   register, the product register and the result register, in that order.
//   Throughput: one sample per cycle while out_ready_i stays high. The integral
//   loop (saturating add, 16x32 multiply against ki, compare against +/-1.0)
//   closes inside the product stage, so back-to-back samples see up-to-date state.
//   Stall: when the receiver holds out_ready_i low, the result register holds
//   its word and the stages behind it fill up; in_ready_o drops only once all
//   three stages hold a word.
//   Reset: the integral, the previous error, all gains, the limit and all
//   valid flags clear to zero.
`default_nettype none

module pid_controller_step (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration write channel.
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [30:0]        cfg_data_i,
  // Sample input channel.
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic signed [15:0] error_sample_i,
  // Result output channel.
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic signed [10:0] drive_value_o,
  output      logic               output_saturated_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers. The port never stalls.
  // ---------------------------------------------------------------------------
  logic signed [15:0] kp_q, ki_q, kd_q;
  logic        [30:0] limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      ki_q    <= '0;
      kd_q    <= '0;
      limit_q <= '0;
    end else if (cfg_valid_i) begin
      case (pidc_pkg::cfg_reg_e'(cfg_index_i))
        pidc_pkg::REG_KP_GAIN:        kp_q    <= cfg_data_i[15:0];
        pidc_pkg::REG_KI_GAIN:        ki_q    <= cfg_data_i[15:0];
        pidc_pkg::REG_KD_GAIN:        kd_q    <= cfg_data_i[15:0];
        pidc_pkg::REG_INTEGRAL_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage loads when it is empty or when the
  // stage ahead of it loads, so bubbles collapse under backpressure.
  // ---------------------------------------------------------------------------
  logic v0_q, v1_q, v2_q;
  logic en0, en1, en2;

  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign en0        = !v0_q || en1;
  assign in_ready_o = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
    end
  end

  // Stage 0: input register.
  logic signed [15:0] err0_q;

  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      err0_q <= error_sample_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: integral update with anti-windup and the three gain products.
  // The integral and the previous error advance when the word in stage 0
  // moves on, so they always reflect every earlier sample.
  // ---------------------------------------------------------------------------
  logic signed [31:0] integ_q, integ_d;
  logic signed [15:0] prev_err_q;
  logic signed [32:0] acc_wide;
  logic signed [31:0] acc;
  logic signed [47:0] i_prod;
  logic signed [47:0] ki_lim;
  logic signed [31:0] lim_pos, lim_neg;
  logic               ki_pos, clamp_hi, clamp_lo;
  logic signed [47:0] i_term_d;
  logic signed [16:0] delta;
  logic signed [31:0] p_term_d;
  logic signed [32:0] d_term_d;
  logic               adv1;

  assign adv1 = v0_q && en1;

  // Saturating accumulate of the sample into the integral.
  assign acc_wide = 33'(integ_q) + 33'(err0_q);
  always_comb begin
    if (acc_wide[32] != acc_wide[31]) begin
      acc = acc_wide[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      acc = acc_wide[31:0];
    end
  end

  assign i_prod   = ki_q * acc;
  assign lim_pos  = {1'b0, limit_q};
  assign lim_neg  = -lim_pos;
  // ki times the limit; a clamped integral term is this value or its negation.
  assign ki_lim   = ki_q * lim_pos;
  assign ki_pos   = !ki_q[15] && (ki_q != '0);
  assign clamp_hi = i_prod > pidc_pkg::ONE_Q16;
  assign clamp_lo = i_prod < pidc_pkg::NEG_ONE_Q16;

  always_comb begin
    integ_d  = acc;
    i_term_d = i_prod;
    if (clamp_hi) begin
      integ_d = ki_pos ? lim_pos : lim_neg;
    end else if (clamp_lo) begin
      integ_d = ki_pos ? lim_neg : lim_pos;
    end
    // The loaded limit is positive exactly when the violated bound and the
    // sign of ki agree.
    if (clamp_hi || clamp_lo) begin
      i_term_d = (clamp_hi == ki_pos) ? ki_lim : -ki_lim;
    end
  end

  assign delta    = 17'(err0_q) - 17'(prev_err_q);
  assign p_term_d = kp_q * err0_q;
  assign d_term_d = kd_q * delta;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      prev_err_q <= '0;
    end else if (adv1) begin
      integ_q    <= integ_d;
      prev_err_q <= err0_q;
    end
  end

  logic signed [31:0] p_term_q;
  logic signed [47:0] i_term_q;
  logic signed [32:0] d_term_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      p_term_q <= p_term_d;
      i_term_q <= i_term_d;
      d_term_q <= d_term_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: sum, saturate to +/-3.0 and round to Q3.8 (ties go up).
  // ---------------------------------------------------------------------------
  logic signed [49:0] raw_sum;
  logic signed [18:0] raw_clamped;
  logic signed [19:0] rounded;
  logic               sat_hi, sat_lo;

  assign raw_sum = 50'(p_term_q) + 50'(i_term_q) + 50'(d_term_q);
  assign sat_hi  = raw_sum > pidc_pkg::THREE_Q16;
  assign sat_lo  = raw_sum < pidc_pkg::NEG_THREE_Q16;

  always_comb begin
    if (sat_hi) begin
      raw_clamped = 19'(pidc_pkg::THREE_Q16);
    end else if (sat_lo) begin
      raw_clamped = 19'(pidc_pkg::NEG_THREE_Q16);
    end else begin
      raw_clamped = raw_sum[18:0];
    end
  end

  assign rounded = 20'(raw_clamped) + pidc_pkg::HALF_LSB_Q16;

  logic signed [10:0] drive_q;
  logic               sat_q;

  always_ff @(posedge clk_i) begin
    if (v1_q && en2) begin
      drive_q <= rounded[18:8];
      sat_q   <= sat_hi || sat_lo;
    end
  end

  assign out_valid_o        = v2_q;
  assign drive_value_o      = drive_q;
  assign output_saturated_o = sat_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_value_o <= 11'sd768) && (drive_value_o >= -11'sd768))
    else $error("drive value outside +/-3.0");

  a_sat_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && output_saturated_o) |->
      (drive_value_o == 11'sd768) || (drive_value_o == -11'sd768))
    else $error("saturated result not at the output bound");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v0_q && v1_q && v2_q && !out_ready_i))
    else $error("input stalled while the pipeline has a free stage");

  a_state_follows_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv1 |=> (prev_err_q == $past(err0_q)) && v1_q)
    else $error("previous error not taken from the advancing sample");

endmodule

`default_nettype wire
